// ===== rtl/imh_pkg.sv =====
`default_nettype none
package imh_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int HSPACE       = 1024;
  localparam int HW           = 10;
  localparam int HCW          = 11;
  localparam int KW           = 32;
  localparam int CW           = 11;

  typedef enum logic [1:0] {
    MODE_INS  = 2'd0,
    MODE_DMIN = 2'd1,
    MODE_DEL  = 2'd2,
    MODE_MOD  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_STALE = 2'd3
  } status_t;

  // One heap slot: its key and the handle that owns it.
  typedef struct packed {
    logic signed [KW-1:0] key;
    logic [HW-1:0]        own;
  } ent_t;

endpackage
`default_nettype wire

// ===== rtl/imh_if.sv =====
`default_nettype none
interface imh_in_if import imh_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [HW-1:0]        handle;
  logic signed [KW-1:0] value;

  modport source (output valid, mode, handle, value, input ready);
  modport sink (input valid, mode, handle, value, output ready);
endinterface

interface imh_out_if import imh_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [KW-1:0] min_value;
  logic                 is_empty;
  logic [CW-1:0]        entry_count;
  logic [HW-1:0]        new_handle;
  logic [1:0]           status;

  modport source (output valid, min_value, is_empty, entry_count, new_handle, status,
                  input ready);
  modport sink (input valid, min_value, is_empty, entry_count, new_handle, status,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/imh_ram.sv =====
`default_nettype none
module imh_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/indexed_min_heap.sv =====
// Indexed binary min-heap of signed 32-bit keys.
// The in_ch channel carries one operation per beat: insert (the key receives
// the next handle in insertion order), delete minimum, delete by handle or
// change the key of a handle. The out_ch channel returns exactly one beat per
// operation with the minimum key, empty flag, entry count, the handle just
// assigned and a status code (full, empty, stale handle are refused).
// The block works on one operation at a time. The heap memory has a
// single read port; each sift step reads it once or twice and writes back.
// A new operation is accepted as soon as the previous one has finished, even
// while its result beat still waits in the output register; a stalled
// receiver only holds the next result back at its last step.
// After reset the heap is empty and handles start at zero. Memories need no
// clearing pass: a handle's slot is only used after it has been given out.
`default_nettype none
module indexed_min_heap import imh_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  imh_in_if.sink   in_ch,
  imh_out_if.source out_ch
);

  localparam int PW = $clog2(CAPACITY + 1);
  typedef logic [PW-1:0] pos_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HS_CHK, S_RM_OWN, S_RM_LAST, S_RM_TAKE, S_UP_RD, S_UP_CMP,
    S_DN_RD, S_DN_L, S_DN_R, S_DN_DEC, S_PLACE, S_FIN, S_RESP
  } state_t;

  state_t   state_r, state_nxt;
  mode_t    mode_r, mode_nxt;
  status_t  status_r, status_nxt;
  logic [HW-1:0]  h_r, h_nxt;
  logic [HW-1:0]  gone_r, gone_nxt;
  logic [HW-1:0]  given_r, given_nxt;
  logic [HCW-1:0] nh_r, nh_nxt;
  pos_t     cnt_r, cnt_nxt;
  pos_t     p_r, p_nxt;
  pos_t     bp_r, bp_nxt;
  ent_t     e_r, e_nxt;
  ent_t     b_r, b_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [KW-1:0] out_min_r, out_min_nxt;
  logic                 out_empty_r, out_empty_nxt;
  logic [CW-1:0]        out_count_r, out_count_nxt;
  logic [HW-1:0]        out_handle_r, out_handle_nxt;
  logic [1:0]           out_status_r, out_status_nxt;

  // Heap memory (positions 1..CAPACITY) and handle-to-position memory.
  logic          hp_we, hp_re;
  pos_t          hp_waddr, hp_raddr;
  ent_t          hp_wdata, hp_rdata;
  logic          hs_we, hs_re;
  logic [HW-1:0] hs_waddr, hs_raddr;
  pos_t          hs_wdata, hs_rdata;

  logic [PW:0] lpos, rpos, cnt_ext;

  imh_ram #(.W($bits(ent_t)), .D(CAPACITY + 1)) u_heap_ram (
    .clk(clk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
    .re(hp_re), .raddr(hp_raddr), .rdata(hp_rdata)
  );

  imh_ram #(.W(PW), .D(HSPACE)) u_slot_ram (
    .clk(clk), .we(hs_we), .waddr(hs_waddr), .wdata(hs_wdata),
    .re(hs_re), .raddr(hs_raddr), .rdata(hs_rdata)
  );

  assign lpos    = {p_r, 1'b0};
  assign rpos    = lpos + (PW + 1)'(1);
  assign cnt_ext = {1'b0, cnt_r};

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.min_value   = out_min_r;
  assign out_ch.is_empty    = out_empty_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.new_handle  = out_handle_r;
  assign out_ch.status      = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    status_nxt     = status_r;
    h_nxt          = h_r;
    gone_nxt       = gone_r;
    given_nxt      = given_r;
    nh_nxt         = nh_r;
    cnt_nxt        = cnt_r;
    p_nxt          = p_r;
    bp_nxt         = bp_r;
    e_nxt          = e_r;
    b_nxt          = b_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_min_nxt    = out_min_r;
    out_empty_nxt  = out_empty_r;
    out_count_nxt  = out_count_r;
    out_handle_nxt = out_handle_r;
    out_status_nxt = out_status_r;
    hp_we    = 1'b0;
    hp_waddr = p_r;
    hp_wdata = e_r;
    hp_re    = 1'b0;
    hp_raddr = p_r;
    hs_we    = 1'b0;
    hs_waddr = e_r.own;
    hs_wdata = p_r;
    hs_re    = 1'b0;
    hs_raddr = in_ch.handle;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt   = mode_t'(in_ch.mode);
          h_nxt      = in_ch.handle;
          e_nxt.key  = in_ch.value;
          given_nxt  = '0;
          status_nxt = STAT_OK;
          unique case (mode_t'(in_ch.mode))
            MODE_INS: begin
              if (cnt_r >= PW'(CAPACITY) || nh_r >= HCW'(HSPACE)) begin
                status_nxt = STAT_FULL;
                state_nxt  = S_FIN;
              end else begin
                e_nxt.own = nh_r[HW-1:0];
                given_nxt = nh_r[HW-1:0];
                p_nxt     = cnt_r + PW'(1);
                cnt_nxt   = cnt_r + PW'(1);
                nh_nxt    = nh_r + HCW'(1);
                state_nxt = S_UP_RD;
              end
            end
            MODE_DMIN: begin
              if (cnt_r == '0) begin
                status_nxt = STAT_EMPTY;
                state_nxt  = S_FIN;
              end else begin
                p_nxt     = PW'(1);
                state_nxt = S_RM_OWN;
              end
            end
            default: begin
              hs_re     = 1'b1;
              state_nxt = S_HS_CHK;
            end
          endcase
        end
      end
      S_HS_CHK: begin
        // A handle not yet given out never had its slot written.
        if ({1'b0, h_r} >= nh_r || hs_rdata == '0 || hs_rdata > cnt_r) begin
          status_nxt = STAT_STALE;
          state_nxt  = S_FIN;
        end else begin
          p_nxt = hs_rdata;
          if (mode_r == MODE_MOD) begin
            e_nxt.own = h_r;
            state_nxt = S_UP_RD;
          end else begin
            state_nxt = S_RM_OWN;
          end
        end
      end
      S_RM_OWN: begin
        hp_re     = 1'b1;
        state_nxt = S_RM_LAST;
      end
      S_RM_LAST: begin
        gone_nxt  = hp_rdata.own;
        hp_re     = 1'b1;
        hp_raddr  = cnt_r;
        state_nxt = S_RM_TAKE;
      end
      S_RM_TAKE: begin
        // The last entry fills the hole left by the removed one.
        e_nxt    = hp_rdata;
        hs_we    = 1'b1;
        hs_waddr = gone_r;
        hs_wdata = '0;
        cnt_nxt  = cnt_r - PW'(1);
        state_nxt = (p_r < cnt_r) ? S_UP_RD : S_FIN;
      end
      S_UP_RD: begin
        if (p_r == PW'(1)) begin
          state_nxt = S_DN_RD;
        end else begin
          hp_re     = 1'b1;
          hp_raddr  = p_r >> 1;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if ($signed(hp_rdata.key) > $signed(e_r.key)) begin
          hp_we     = 1'b1;
          hp_wdata  = hp_rdata;
          hs_we     = 1'b1;
          hs_waddr  = hp_rdata.own;
          p_nxt     = p_r >> 1;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_DN_RD: begin
        if (lpos > cnt_ext) begin
          state_nxt = S_PLACE;
        end else begin
          hp_re     = 1'b1;
          hp_raddr  = lpos[PW-1:0];
          state_nxt = S_DN_L;
        end
      end
      S_DN_L: begin
        if ($signed(hp_rdata.key) < $signed(e_r.key)) begin
          b_nxt  = hp_rdata;
          bp_nxt = lpos[PW-1:0];
        end else begin
          b_nxt  = e_r;
          bp_nxt = p_r;
        end
        if (rpos <= cnt_ext) begin
          hp_re     = 1'b1;
          hp_raddr  = rpos[PW-1:0];
          state_nxt = S_DN_R;
        end else begin
          state_nxt = S_DN_DEC;
        end
      end
      S_DN_R: begin
        if ($signed(hp_rdata.key) < $signed(b_r.key)) begin
          b_nxt  = hp_rdata;
          bp_nxt = rpos[PW-1:0];
        end
        state_nxt = S_DN_DEC;
      end
      S_DN_DEC: begin
        if (bp_r == p_r) begin
          state_nxt = S_PLACE;
        end else begin
          hp_we     = 1'b1;
          hp_wdata  = b_r;
          hs_we     = 1'b1;
          hs_waddr  = b_r.own;
          p_nxt     = bp_r;
          state_nxt = S_DN_RD;
        end
      end
      S_PLACE: begin
        hp_we     = 1'b1;
        hs_we     = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        hp_re     = 1'b1;
        hp_raddr  = PW'(1);
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_min_nxt    = (cnt_r != '0) ? hp_rdata.key : '0;
          out_empty_nxt  = (cnt_r == '0);
          out_count_nxt  = CW'(cnt_r);
          out_handle_nxt = given_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      nh_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      nh_r        <= nh_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    status_r     <= status_nxt;
    h_r          <= h_nxt;
    gone_r       <= gone_nxt;
    given_r      <= given_nxt;
    p_r          <= p_nxt;
    bp_r         <= bp_nxt;
    e_r          <= e_nxt;
    b_r          <= b_nxt;
    out_min_r    <= out_min_nxt;
    out_empty_r  <= out_empty_nxt;
    out_count_r  <= out_count_nxt;
    out_handle_r <= out_handle_nxt;
    out_status_r <= out_status_nxt;
  end

  // The fill count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= PW'(CAPACITY))
    else $error("fill count above capacity");

  // One operation adds or removes at most one entry.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != $past(cnt_r) |-> (cnt_r == $past(cnt_r) + PW'(1) ||
                               cnt_r == $past(cnt_r) - PW'(1)))
    else $error("fill count jumped");

  // A position recorded for a handle always lies inside the heap.
  a_slot_pos: assert property (@(posedge clk) disable iff (!rst_n)
    hs_we && hs_wdata != '0 |-> hs_wdata <= cnt_r)
    else $error("handle mapped past the last entry");

  // Handles are only ever counted up, by one at a time.
  a_nh_step: assert property (@(posedge clk) disable iff (!rst_n)
    nh_r != $past(nh_r) |-> nh_r == $past(nh_r) + HCW'(1))
    else $error("handle counter moved wrongly");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import imh_pkg::*;

  // One operation as offered on the input channel.
  typedef struct packed {
    mode_t                mode;
    logic [HW-1:0]        handle;
    logic signed [KW-1:0] value;
  } heap_op_t;

  // One result beat as the heap reports it.
  typedef struct packed {
    logic signed [KW-1:0] min_value;
    logic                 is_empty;
    logic [CW-1:0]        entry_count;
    logic [HW-1:0]        new_handle;
    status_t              status;
  } heap_report_t;

  localparam int HEAP_DEPTH = CAPACITY_DEF;
  // Shadow heaps: the planner copy steers stimulus toward live handles,
  // the checker copy follows accepted beats and predicts each report.
  localparam int PLAN = 0;
  localparam int CHECK = 1;

  logic clk;
  logic rst_n;

  imh_in_if  in_bus ();
  imh_out_if out_bus ();

  indexed_min_heap #(.CAPACITY(HEAP_DEPTH)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Shadow heap state. Positions are 1-based; pos_of == 0 means the handle
  // holds no entry.
  // ---------------------------------------------------------------------
  logic signed [KW-1:0] key_at [2][1:HEAP_DEPTH];
  logic [HW-1:0]        own_at [2][1:HEAP_DEPTH];
  int                   pos_of [2][0:HSPACE-1];
  int                   fill   [2];
  int                   issued [2];

  function automatic void clear_heap(input int p);
    for (int i = 0; i < HSPACE; i++) pos_of[p][i] = 0;
    fill[p] = 0;
    issued[p] = 0;
  endfunction

  // Swap two positions and keep both handle maps in step.
  function automatic void swap_pos(input int p, input int a, input int b);
    logic [HW-1:0]        ha;
    logic [HW-1:0]        hb;
    logic signed [KW-1:0] k;
    ha = own_at[p][a];
    hb = own_at[p][b];
    k = key_at[p][a];
    pos_of[p][ha] = b;
    pos_of[p][hb] = a;
    own_at[p][a] = hb;
    own_at[p][b] = ha;
    key_at[p][a] = key_at[p][b];
    key_at[p][b] = k;
  endfunction

  // Moves past strictly greater parents only.
  function automatic void bubble_up(input int p, input int start);
    int pos;
    pos = start;
    while (pos > 1 && key_at[p][pos / 2] > key_at[p][pos]) begin
      swap_pos(p, pos / 2, pos);
      pos = pos / 2;
    end
  endfunction

  // Moves past strictly smaller children; the left child wins a tie.
  function automatic void push_down(input int p, input int start);
    int pos;
    int best;
    int l;
    pos = start;
    forever begin
      best = pos;
      l = pos * 2;
      if (l <= fill[p] && key_at[p][l] < key_at[p][best]) best = l;
      if (l + 1 <= fill[p] && key_at[p][l + 1] < key_at[p][best]) best = l + 1;
      if (best == pos) return;
      swap_pos(p, pos, best);
      pos = best;
    end
  endfunction

  function automatic void remove_pos(input int p, input int pos);
    int last;
    last = fill[p];
    swap_pos(p, pos, last);
    pos_of[p][own_at[p][last]] = 0;
    fill[p] = last - 1;
    if (pos <= fill[p]) begin
      bubble_up(p, pos);
      push_down(p, pos);
    end
  endfunction

  // Applies one operation to a shadow heap and returns the report it causes.
  function automatic heap_report_t apply_op(input int p, input heap_op_t op);
    heap_report_t rep;
    int pos;
    rep = '0;
    rep.status = STAT_OK;
    case (op.mode)
      MODE_INS: begin
        if (fill[p] >= HEAP_DEPTH || issued[p] >= HSPACE) begin
          rep.status = STAT_FULL;
        end else begin
          pos = fill[p] + 1;
          rep.new_handle = issued[p][HW-1:0];
          fill[p] = pos;
          pos_of[p][issued[p]] = pos;
          own_at[p][pos] = issued[p][HW-1:0];
          key_at[p][pos] = op.value;
          issued[p]++;
          bubble_up(p, pos);
        end
      end
      MODE_DMIN: begin
        if (fill[p] == 0) rep.status = STAT_EMPTY;
        else remove_pos(p, 1);
      end
      default: begin
        pos = pos_of[p][op.handle];
        if (op.handle >= issued[p] || pos == 0 || pos > fill[p]) begin
          rep.status = STAT_STALE;
        end else if (op.mode == MODE_DEL) begin
          remove_pos(p, pos);
        end else begin
          key_at[p][pos] = op.value;
          bubble_up(p, pos);
          push_down(p, pos_of[p][op.handle]);
        end
      end
    endcase
    rep.min_value = (fill[p] != 0) ? key_at[p][1] : '0;
    rep.is_empty = (fill[p] == 0);
    rep.entry_count = fill[p][CW-1:0];
    return rep;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus planning.
  // ---------------------------------------------------------------------
  heap_op_t     pending_ops [$];
  heap_report_t expected_reports [$];
  int           total_ops;

  // Keys: full-range, tiny (many ties), extremes, or a moderate spread.
  function automatic logic signed [KW-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 6)) - 3;
      2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  // Handle of an entry that is currently held.
  function automatic logic [HW-1:0] live_handle();
    return own_at[PLAN][$urandom_range(1, fill[PLAN])];
  endfunction

  function automatic void plan(input mode_t m, input logic [HW-1:0] h,
                               input logic signed [KW-1:0] v);
    heap_op_t op;
    op.mode = m;
    op.handle = h;
    op.value = v;
    void'(apply_op(PLAN, op));
    pending_ops.push_back(op);
  endfunction

  task automatic build_stimulus();
    int r;
    clear_heap(PLAN);
    // Directed opening: empty heap, stale handles, extreme and equal keys.
    plan(MODE_DMIN, '0, '0);
    plan(MODE_DEL, '0, '0);
    plan(MODE_MOD, 10'd5, 32'sd1);
    plan(MODE_INS, '0, 32'sh7fff_ffff);
    plan(MODE_INS, '1, 32'sh8000_0000);
    plan(MODE_INS, '0, 32'sd0);
    plan(MODE_INS, '0, 32'sd7);
    plan(MODE_INS, '0, 32'sd7);
    plan(MODE_INS, '0, 32'sd7);
    plan(MODE_MOD, 10'd0, 32'sh8000_0000);
    plan(MODE_MOD, 10'd1, 32'sh7fff_ffff);
    plan(MODE_MOD, 10'd4, 32'sd7);
    plan(MODE_MOD, 10'd5, 32'sd0);
    plan(MODE_DEL, 10'h3ff, '1);
    plan(MODE_MOD, 10'd6, 32'sd3);

    // Mostly inserts until every handle has been given out, so the heap
    // grows deep; deletes, modifies and unknown handles are mixed in.
    while (issued[PLAN] < HSPACE) begin
      r = $urandom_range(0, 99);
      if (r < 94 || fill[PLAN] == 0) plan(MODE_INS, HW'($urandom), pick_key());
      else if (r < 97) plan(MODE_MOD, live_handle(), pick_key());
      else if (r < 98) plan(MODE_DEL, live_handle(), $urandom);
      else if (r < 99) plan(MODE_DMIN, HW'($urandom), $urandom);
      else plan($urandom_range(0, 1) ? MODE_DEL : MODE_MOD,
                HW'($urandom_range(issued[PLAN], HSPACE - 1)), pick_key());
    end
    // No handles left: these inserts are refused.
    repeat (3) plan(MODE_INS, HW'($urandom), pick_key());

    // A few deep operations on the large heap once handles are exhausted.
    plan(MODE_DMIN, '0, '0);
    plan(MODE_DEL, live_handle(), '0);
    plan(MODE_MOD, live_handle(), 32'sh8000_0000);
    plan(MODE_DMIN, '0, '0);
    plan(MODE_INS, '0, 32'sd9);
    total_ops = pending_ops.size();
  endtask

  // ---------------------------------------------------------------------
  // Handshake bookkeeping. Beats are sampled at the rising edge; the
  // driver and the receiver react at the falling edge.
  // ---------------------------------------------------------------------
  bit in_beat;
  int ops_sent;
  int reports_seen;
  int mismatches;
  int status_tally [4];
  bit long_hold;
  int src_gap;
  int snk_gap;

  always @(posedge clk) begin
    heap_op_t     op;
    heap_report_t got;
    heap_report_t want;
    in_beat = rst_n && in_bus.valid && in_bus.ready;
    if (in_beat) begin
      op.mode = mode_t'(in_bus.mode);
      op.handle = in_bus.handle;
      op.value = in_bus.value;
      expected_reports.push_back(apply_op(CHECK, op));
      ops_sent++;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.min_value = out_bus.min_value;
      got.is_empty = out_bus.is_empty;
      got.entry_count = out_bus.entry_count;
      got.new_handle = out_bus.new_handle;
      got.status = status_t'(out_bus.status);
      reports_seen++;
      status_tally[got.status]++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: report beat %0d arrived with none expected", reports_seen);
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: report %0d: expected min=%0d empty=%0b count=%0d ",
                      "handle=%0d status=%0d, got min=%0d empty=%0b count=%0d ",
                      "handle=%0d status=%0d"}, reports_seen,
                     want.min_value, want.is_empty, want.entry_count,
                     want.new_handle, want.status, got.min_value, got.is_empty,
                     got.entry_count, got.new_handle, got.status);
        end
      end
    end
  end

  // The sender holds an offered beat until it is taken, and otherwise
  // idles in short random bursts except near the end of the run.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_beat) void'(pending_ops.pop_front());
      if (in_bus.valid && !in_beat) begin
        // The offer stands until the heap takes it.
      end else if (src_gap > 0) begin
        src_gap--;
        in_bus.valid <= 1'b0;
      end else if (pending_ops.size() == 0) begin
        in_bus.valid <= 1'b0;
      end else if (ops_sent < total_ops - 150 && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(1, 6) - 1;
        in_bus.valid <= 1'b0;
      end else begin
        in_bus.valid <= 1'b1;
        in_bus.mode <= pending_ops[0].mode;
        in_bus.handle <= pending_ops[0].handle;
        in_bus.value <= pending_ops[0].value;
      end
    end
  end

  // The receiver stalls in random bursts, and once for a long stretch.
  always @(negedge clk) begin
    if (rst_n) begin
      if (long_hold) begin
        out_bus.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_bus.ready <= 1'b0;
      end else if (ops_sent < total_ops - 150 && $urandom_range(0, 5) == 0) begin
        snk_gap = $urandom_range(1, 6) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Long receiver stall while inserts keep coming: the output register
  // fills and the heap must stop taking input.
  initial begin
    long_hold = 1'b0;
    wait (ops_sent >= 200);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (400) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("indexed_min_heap test failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.mode = '0;
    in_bus.handle = '0;
    in_bus.value = '0;
    out_bus.ready = 1'b0;
    clear_heap(CHECK);
    build_stimulus();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    wait (ops_sent == total_ops);
    wait (expected_reports.size() == 0);
    repeat (100) @(posedge clk);

    $display("Ran %0d heap operations, inserting until every handle was used up,",
             total_ops);
    $display("with deletes, key changes and stale handles mixed in; statuses: %s",
             $sformatf("ok %0d, full %0d, empty %0d, stale %0d.",
                       status_tally[STAT_OK], status_tally[STAT_FULL],
                       status_tally[STAT_EMPTY], status_tally[STAT_STALE]));
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("indexed_min_heap test passed");
    end else begin
      $display("indexed_min_heap test failed");
    end
    $finish;
  end

endmodule
